// ===== src/npps_pkg.sv =====
`default_nettype none
package npps_pkg;
    localparam int COORD_BITS_DEF      = 24;
    localparam int T_FRAC_BITS_DEF     = 16;
    localparam int EDGE_INDEX_BITS_DEF = 20;

    // fixed field widths of the stream payloads
    localparam int FIELD_COORD_W = 24;
    localparam int FIELD_EDGE_W  = 20;
    localparam int FIELD_DIST_W  = 25;
    localparam int IN_DATA_W     = 96;
    localparam int OUT_DATA_W    = 96;
endpackage
`default_nettype wire

// ===== src/npps_isqrt.sv =====
`default_nettype none
module npps_isqrt #(
    parameter int VALUE_BITS = 51
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [VALUE_BITS-1:0]           value,
    output logic                                 done,
    output logic [(VALUE_BITS+VALUE_BITS%2)/2-1:0] root
);
    localparam int PW = VALUE_BITS + VALUE_BITS % 2;
    localparam int RW = PW / 2;

    logic          busy_reg;
    logic          done_reg;
    logic [PW-1:0] v_reg;
    logic [PW-1:0] r_reg;
    logic [PW-1:0] bit_reg;
    logic [PW-1:0] trial;

    assign trial = r_reg + bit_reg;

    // one result bit per cycle, restoring square root
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                v_reg    <= PW'(value);
                r_reg    <= '0;
                bit_reg  <= PW'(1) << (PW - 2);
            end
            else if (busy_reg)
            begin
                if (v_reg >= trial)
                begin
                    v_reg <= v_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0])
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = r_reg[RW-1:0];
endmodule
`default_nettype wire

// ===== src/nearest_polyline_point_search.sv =====
// A vertex without a segment is only registered. A vertex closing a segment runs its steps
// (four products on the shared multiplier, a one-bit-per-cycle divider, two snap products,
// two distance products); the divider is skipped when t clamps.
// A vertex ending a query adds the square root and the result load.
// One item is in work at a time; a finished result waits in the output register and
// stalls the input only while the previous result is still untaken.
// rst_n clears the query point, previous vertex, edge counter and best-so-far asynchronously.
`default_nettype none
module nearest_polyline_point_search import npps_pkg::*; #(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int T_FRAC_BITS     = T_FRAC_BITS_DEF,
    parameter int EDGE_INDEX_BITS = EDGE_INDEX_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // vertex_x, vertex_y, point_x, point_y (24 bits each)
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // starts_edge, starts_query
    input  wire logic [1:0]            s_tuser,
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // edge_number(20), snapped_x(24), snapped_y(24), distance(25), 3 zero bits
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // found
    output logic                       m_tuser
);
    localparam int CW   = COORD_BITS;
    localparam int F    = T_FRAC_BITS;
    localparam int EB   = EDGE_INDEX_BITS;
    localparam int MW   = (CW + 1 > F + 2) ? CW + 1 : F + 2;
    localparam int NW   = 2 * CW + 3;
    localparam int RW   = (NW + NW % 2) / 2;
    localparam int CNTW = $clog2(F + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DEN0, S_DEN1, S_NUM0, S_NUM1, S_CHECK, S_DIV,
        S_CX, S_CY, S_E0, S_E1, S_ROOT, S_RWAIT, S_OUT
    } state_t;

    state_t                state_reg;
    logic signed [CW-1:0]  qx_reg, qy_reg, prev_x_reg, prev_y_reg, ax_reg, ay_reg;
    logic signed [CW-1:0]  cx_reg, cy_reg, best_px_reg, best_py_reg;
    logic                  have_prev_reg, ends_reg, best_valid_reg, out_valid_reg;
    logic [EB-1:0]         edge_reg, best_edge_reg;
    logic [NW-1:0]         best_sq_reg, den_reg, rem_reg;
    logic signed [CW:0]    abx_reg, aby_reg, apx_reg, apy_reg;
    logic signed [NW-1:0]  acc_reg;
    logic [F-1:0]          quo_reg;
    logic [F:0]            t_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_found_reg;

    logic signed [CW-1:0]   vx, vy, px, py;
    logic                   accept, seg, load_out;
    logic signed [CW:0]     ex, ey;
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] prod, snap_sum;
    logic signed [NW-1:0]   prod_n, sum_n;
    logic [NW:0]            rem_sh;
    logic                   root_start, root_done;
    logic [RW-1:0]          root;

    assign vx = s_tdata[CW-1:0];
    assign vy = s_tdata[FIELD_COORD_W+CW-1:FIELD_COORD_W];
    assign px = s_tdata[2*FIELD_COORD_W+CW-1:2*FIELD_COORD_W];
    assign py = s_tdata[3*FIELD_COORD_W+CW-1:3*FIELD_COORD_W];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign seg      = have_prev_reg && !s_tuser[1] && !s_tuser[0];
    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    assign ex = (CW+1)'(cx_reg) - (CW+1)'(qx_reg);
    assign ey = (CW+1)'(cy_reg) - (CW+1)'(qy_reg);

    // pick operands of the shared multiplier
    always_comb
    begin
        unique case (state_reg)
            S_DEN0:  begin mul_a = MW'(abx_reg); mul_b = MW'(abx_reg); end
            S_DEN1:  begin mul_a = MW'(aby_reg); mul_b = MW'(aby_reg); end
            S_NUM0:  begin mul_a = MW'(apx_reg); mul_b = MW'(abx_reg); end
            S_NUM1:  begin mul_a = MW'(apy_reg); mul_b = MW'(aby_reg); end
            S_CX:    begin mul_a = MW'(abx_reg); mul_b = MW'($signed({1'b0, t_reg})); end
            S_CY:    begin mul_a = MW'(aby_reg); mul_b = MW'($signed({1'b0, t_reg})); end
            S_E0:    begin mul_a = MW'(ex);      mul_b = MW'(ex); end
            S_E1:    begin mul_a = MW'(ey);      mul_b = MW'(ey); end
            default: begin mul_a = '0;           mul_b = '0; end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_n   = NW'(prod);
    assign sum_n    = acc_reg + prod_n;
    assign snap_sum = (state_reg == S_CX ? (2*MW)'(ax_reg) : (2*MW)'(ay_reg)) + (prod >>> F);
    assign rem_sh   = {rem_reg, 1'b0};

    assign root_start = (state_reg == S_ROOT);

    npps_isqrt #(
        .VALUE_BITS(NW)
    ) u_isqrt (
        .clk  (clk),
        .rst_n(rst_n),
        .start(root_start),
        .value(best_sq_reg),
        .done (root_done),
        .root (root)
    );

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            qx_reg         <= '0;
            qy_reg         <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            have_prev_reg  <= 1'b0;
            edge_reg       <= '0;
            best_valid_reg <= 1'b0;
            best_sq_reg    <= '0;
            best_px_reg    <= '0;
            best_py_reg    <= '0;
            best_edge_reg  <= '0;
            ends_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (s_tuser[1])
                        begin
                            qx_reg         <= px;
                            qy_reg         <= py;
                            best_valid_reg <= 1'b0;
                            best_sq_reg    <= '0;
                            best_px_reg    <= '0;
                            best_py_reg    <= '0;
                            best_edge_reg  <= '0;
                            edge_reg       <= '0;
                        end
                        else if (s_tuser[0])
                        begin
                            edge_reg <= edge_reg + 1'b1;
                        end
                        ax_reg        <= prev_x_reg;
                        ay_reg        <= prev_y_reg;
                        abx_reg       <= (CW+1)'(vx) - (CW+1)'(prev_x_reg);
                        aby_reg       <= (CW+1)'(vy) - (CW+1)'(prev_y_reg);
                        apx_reg       <= (CW+1)'(qx_reg) - (CW+1)'(prev_x_reg);
                        apy_reg       <= (CW+1)'(qy_reg) - (CW+1)'(prev_y_reg);
                        prev_x_reg    <= vx;
                        prev_y_reg    <= vy;
                        have_prev_reg <= 1'b1;
                        ends_reg      <= s_tlast;
                        if (seg)
                            state_reg <= S_DEN0;
                        else if (s_tlast)
                            state_reg <= S_ROOT;
                    end
                end
                S_DEN0:
                begin
                    acc_reg   <= prod_n;
                    state_reg <= S_DEN1;
                end
                S_DEN1:
                begin
                    den_reg   <= NW'(sum_n);
                    state_reg <= S_NUM0;
                end
                S_NUM0:
                begin
                    acc_reg   <= prod_n;
                    state_reg <= S_NUM1;
                end
                S_NUM1:
                begin
                    acc_reg   <= sum_n;
                    state_reg <= S_CHECK;
                end
                // clamp or start the divide
                S_CHECK:
                begin
                    if (den_reg == '0 || acc_reg <= 0)
                    begin
                        t_reg     <= '0;
                        state_reg <= S_CX;
                    end
                    else if (NW'(acc_reg) >= den_reg)
                    begin
                        t_reg     <= (F+1)'(1) << F;
                        state_reg <= S_CX;
                    end
                    else
                    begin
                        rem_reg   <= NW'(acc_reg);
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                // one quotient bit per cycle
                S_DIV:
                begin
                    if (rem_sh >= {1'b0, den_reg})
                    begin
                        rem_reg <= NW'(rem_sh - {1'b0, den_reg});
                        quo_reg <= {quo_reg[F-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= NW'(rem_sh);
                        quo_reg <= {quo_reg[F-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNTW'(F - 1))
                        state_reg <= S_CX;
                end
                S_CX:
                begin
                    cx_reg    <= snap_sum[CW-1:0];
                    state_reg <= S_CY;
                end
                S_CY:
                begin
                    cy_reg    <= snap_sum[CW-1:0];
                    state_reg <= S_E0;
                end
                S_E0:
                begin
                    acc_reg   <= prod_n;
                    state_reg <= S_E1;
                end
                // keep the first strict minimum
                S_E1:
                begin
                    if (!best_valid_reg || $unsigned(sum_n) < best_sq_reg)
                    begin
                        best_valid_reg <= 1'b1;
                        best_sq_reg    <= $unsigned(sum_n);
                        best_px_reg    <= cx_reg;
                        best_py_reg    <= cy_reg;
                        best_edge_reg  <= edge_reg;
                    end
                    state_reg <= ends_reg ? S_ROOT : S_IDLE;
                end
                S_ROOT:
                begin
                    state_reg <= S_RWAIT;
                end
                S_RWAIT:
                begin
                    if (root_done)
                        state_reg <= S_OUT;
                end
                // load the result once the output register is free
                S_OUT:
                begin
                    if (load_out)
                    begin
                        out_data_reg <= {
                            {(OUT_DATA_W - FIELD_EDGE_W - 2*FIELD_COORD_W - FIELD_DIST_W){1'b0}},
                            FIELD_DIST_W'(root),
                            FIELD_COORD_W'(best_py_reg),
                            FIELD_COORD_W'(best_px_reg),
                            FIELD_EDGE_W'(best_edge_reg)};
                        out_found_reg <= best_valid_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (state_reg == S_DIV && cnt_reg == CNTW'(F - 1))
                t_reg <= {1'b0, quo_reg[F-2:0], (rem_sh >= {1'b0, den_reg})};
            // hold the result until it is taken
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_found_reg;
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
    import npps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int T_FRAC      = T_FRAC_BITS_DEF;
    localparam int TAIL_CYCLES = 120;
    localparam longint LIMIT_CYCLES = 3000000;

    typedef struct packed {
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic               starts_edge;
        logic               starts_query;
        logic               ends_query;
    } vertex_item_t;

    typedef struct packed {
        logic               found;
        logic [19:0]        edge_idx;
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        logic [24:0]        root_len;
    } nearest_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]        s_tuser;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic              m_tuser;

    nearest_polyline_point_search u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    vertex_item_t pending_items[$];
    nearest_t     expected_nearest[$];
    int           mismatch_count;
    int           sender_idle_pct;
    int           receiver_stall_pct;
    int           hold_off_cycles;
    bit           item_taken;
    longint       cycle_count;

    // search state of the predictor
    longint            qx, qy, prev_x, prev_y;
    bit                have_prev;
    logic [19:0]       edge_cnt;
    bit                best_ok;
    longint unsigned   best_sq;
    longint            best_x, best_y;
    logic [19:0]       best_edge_idx;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // project the query onto segment a-b and keep the first strict minimum
    function automatic void score_segment(input longint ax, input longint ay,
                                          input longint bx, input longint by);
        longint abx, aby, num, den, t, cx, cy, ex, ey;
        longint unsigned rem, sq;
        abx = bx - ax;
        aby = by - ay;
        num = (qx - ax) * abx + (qy - ay) * aby;
        den = abx * abx + aby * aby;
        t = 0;
        if (den > 0 && num > 0)
        begin
            if (num >= den)
                t = longint'(1) << T_FRAC;
            else
            begin
                rem = num;
                for (int i = 0; i < T_FRAC; i++)
                begin
                    rem <<= 1;
                    t <<= 1;
                    if (rem >= den)
                    begin
                        rem -= den;
                        t |= 1;
                    end
                end
            end
        end
        cx = ax + ((abx * t) >>> T_FRAC);
        cy = ay + ((aby * t) >>> T_FRAC);
        ex = cx - qx;
        ey = cy - qy;
        sq = ex * ex + ey * ey;
        if (!best_ok || sq < best_sq)
        begin
            best_ok = 1'b1;
            best_sq = sq;
            best_x = cx;
            best_y = cy;
            best_edge_idx = edge_cnt;
        end
    endfunction

    // advance the search by one vertex; queue a result when the query ends
    function automatic void predict_vertex(input vertex_item_t it);
        nearest_t res;
        if (it.starts_query)
        begin
            qx = it.px;
            qy = it.py;
            best_ok = 1'b0;
            best_sq = 0;
            best_x = 0;
            best_y = 0;
            best_edge_idx = '0;
            edge_cnt = '0;
            have_prev = 1'b0;
        end
        else if (it.starts_edge)
        begin
            edge_cnt = edge_cnt + 1'b1;
            have_prev = 1'b0;
        end
        if (have_prev)
            score_segment(prev_x, prev_y, it.vx, it.vy);
        prev_x = it.vx;
        prev_y = it.vy;
        have_prev = 1'b1;
        if (it.ends_query)
        begin
            res = '0;
            if (best_ok)
            begin
                res.found = 1'b1;
                res.edge_idx = best_edge_idx;
                res.sx = best_x[23:0];
                res.sy = best_y[23:0];
                res.root_len = 25'(int_sqrt(best_sq));
            end
            expected_nearest.insert(expected_nearest.size(), res);
        end
    endfunction

    // drive the next item at the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            s_tlast  <= 1'b0;
        end
        else if (!s_tvalid || item_taken)
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                vertex_item_t it;
                it = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {it.py, it.px, it.vy, it.vx};
                s_tuser  <= {it.starts_query, it.starts_edge};
                s_tlast  <= it.ends_query;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // stall the result side, with an optional long hold-off
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // watch both handshakes at the rising edge
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        item_taken = rst_n && s_tvalid && s_tready;
        if (item_taken)
            predict_vertex({s_tdata[23:0], s_tdata[47:24], s_tdata[71:48], s_tdata[95:72],
                            s_tuser[0], s_tuser[1], s_tlast});
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_nearest.size() == 0)
                report_mismatch("unexpected result, found", m_tuser, -1);
            else
            begin
                nearest_t want;
                want = expected_nearest.pop_front();
                if (m_tuser !== want.found)
                    report_mismatch("found", m_tuser, want.found);
                if (m_tdata[19:0] !== want.edge_idx)
                    report_mismatch("edge_number", m_tdata[19:0], want.edge_idx);
                if (m_tdata[43:20] !== want.sx)
                    report_mismatch("snapped_x", $signed(m_tdata[43:20]), want.sx);
                if (m_tdata[67:44] !== want.sy)
                    report_mismatch("snapped_y", $signed(m_tdata[67:44]), want.sy);
                if (m_tdata[92:68] !== want.root_len)
                    report_mismatch("distance", m_tdata[92:68], want.root_len);
            end
        end
    end

    // bail out on a hang
    always @(posedge clk)
    begin
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic signed [23:0] rand_coord(input bit narrow);
        if (narrow)
            return 24'(int'($urandom_range(16)) - 8);
        return 24'($urandom);
    endfunction

    task automatic add_vertex(input logic signed [23:0] vx, input logic signed [23:0] vy,
                              input logic signed [23:0] px, input logic signed [23:0] py,
                              input bit se, input bit sq, input bit eq);
        vertex_item_t it;
        it.vx = vx;
        it.vy = vy;
        it.px = px;
        it.py = py;
        it.starts_edge = se;
        it.starts_query = sq;
        it.ends_query = eq;
        pending_items.insert(pending_items.size(), it);
    endtask

    // one well-formed query: a few edges of a few vertices each
    task automatic add_query(output int count);
        int  n_edges, n_verts;
        bit  narrow;
        bit  first;
        narrow = 1'($urandom_range(1));
        n_edges = $urandom_range(4, 1);
        count = 0;
        first = 1'b1;
        for (int e = 0; e < n_edges; e++)
        begin
            n_verts = $urandom_range(4, 1);
            for (int v = 0; v < n_verts; v++)
            begin
                add_vertex(rand_coord(narrow), rand_coord(narrow),
                           rand_coord(narrow), rand_coord(narrow),
                           (v == 0) || ($urandom_range(15) == 0), first,
                           (e == n_edges - 1) && (v == n_verts - 1));
                first = 1'b0;
                count++;
            end
        end
    endtask

    task automatic add_noise();
        add_vertex(rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0),
                   1'($urandom_range(1)), $urandom_range(3) == 0, $urandom_range(3) == 0);
    endtask

    task automatic drain_inputs();
        wait (pending_items.size() == 0);
        @(posedge clk);
        while (s_tvalid)
            @(posedge clk);
    endtask

    task automatic run_random(input int n_items);
        int made, got;
        made = 0;
        while (made < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                add_noise();
                made++;
            end
            else
            begin
                add_query(got);
                made += got;
            end
        end
        drain_inputs();
    endtask

    localparam logic signed [23:0] CMAX = 24'sh7FFFFF;
    localparam logic signed [23:0] CMIN = 24'sh800000;

    initial
    begin
        mismatch_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off_cycles = 0;
        item_taken = 1'b0;
        cycle_count = 0;
        qx = 0; qy = 0; prev_x = 0; prev_y = 0;
        have_prev = 1'b0;
        edge_cnt = '0;
        best_ok = 1'b0;
        best_sq = 0;
        best_x = 0; best_y = 0;
        best_edge_idx = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // vertices before any query start, against the origin
        add_vertex(24'sd10, -24'sd5, CMAX, CMIN, 1'b0, 1'b0, 1'b0);
        add_vertex(-24'sd10, 24'sd5, 24'sd0, 24'sd0, 1'b0, 1'b0, 1'b0);
        add_vertex(24'sd3, 24'sd3, 24'sd0, 24'sd0, 1'b1, 1'b0, 1'b0);
        add_vertex(24'sd3, 24'sd9, 24'sd0, 24'sd0, 1'b0, 1'b0, 1'b1);
        // keep going after the end without a new start
        add_vertex(24'sd0, 24'sd1, 24'sd0, 24'sd0, 1'b0, 1'b0, 1'b1);
        // extreme coordinates, far query corner
        add_vertex(CMAX, CMAX, CMIN, CMIN, 1'b0, 1'b1, 1'b0);
        add_vertex(CMIN, CMAX, CMIN, CMIN, 1'b0, 1'b0, 1'b0);
        add_vertex(CMIN, CMIN, CMAX, CMAX, 1'b0, 1'b0, 1'b0);
        // single-vertex edge, then a zero-length segment
        add_vertex(24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b0, 1'b0);
        add_vertex(24'sd7, -24'sd7, 24'sd0, 24'sd0, 1'b1, 1'b0, 1'b0);
        add_vertex(24'sd7, -24'sd7, 24'sd0, 24'sd0, 1'b0, 1'b0, 1'b1);
        // start and end on the same vertex: nothing found
        add_vertex(CMAX, CMIN, CMAX, CMIN, 1'b1, 1'b1, 1'b1);
        // two identical edges tie, the first edge wins
        add_vertex(-24'sd4, 24'sd2, 24'sd0, 24'sd0, 1'b0, 1'b1, 1'b0);
        add_vertex(24'sd4, 24'sd2, 24'sd0, 24'sd0, 1'b0, 1'b0, 1'b0);
        add_vertex(-24'sd4, 24'sd2, 24'sd0, 24'sd0, 1'b1, 1'b0, 1'b0);
        add_vertex(24'sd4, 24'sd2, 24'sd0, 24'sd0, 1'b0, 1'b0, 1'b1);
        // projection clamped at both ends
        add_vertex(24'sd0, 24'sd0, 24'sd100, 24'sd3, 1'b0, 1'b1, 1'b0);
        add_vertex(24'sd10, 24'sd0, 24'sd100, 24'sd3, 1'b0, 1'b0, 1'b0);
        add_vertex(24'sd20, 24'sd7, 24'sd100, 24'sd3, 1'b1, 1'b0, 1'b0);
        add_vertex(24'sd40, 24'sd11, 24'sd100, 24'sd3, 1'b0, 1'b0, 1'b1);
        add_vertex(24'sd5, 24'sd5, -24'sd100, 24'sd3, 1'b0, 1'b1, 1'b0);
        add_vertex(24'sd9, 24'sd0, -24'sd100, 24'sd3, 1'b0, 1'b0, 1'b1);
        drain_inputs();

        // random phases with different idling
        run_random(500);
        sender_idle_pct = 85;
        run_random(300);
        sender_idle_pct = 0;
        receiver_stall_pct = 85;
        run_random(300);
        sender_idle_pct = 34;
        receiver_stall_pct = 34;
        run_random(400);
        // hold the result side off while items keep coming
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        @(negedge clk);
        hold_off_cycles = 400;
        run_random(500);

        wait (expected_nearest.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_nearest.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
